@@ hw/rtl/ifs_pkg.sv @@
// Shared types, constants and the element length table of the fixed field splitter.
package ifs_pkg;

    localparam int NUM_ELEMENTS = 12;
    localparam int TYPE_LEN     = 4;
    localparam int QUEUE_DEPTH  = 4;

    localparam int CHAR_W    = 8;
    localparam int SEC_W     = 2;
    localparam int ELEM_W    = 4;
    localparam int POS_W     = 5;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [CHAR_W-1:0] CHAR_ONE = 8'h31;

    // Section codes carried on the result channel
    localparam logic [SEC_W-1:0] SEC_TYPE   = 2'd0;
    localparam logic [SEC_W-1:0] SEC_BITMAP = 2'd1;
    localparam logic [SEC_W-1:0] SEC_DATA   = 2'd2;
    localparam logic [SEC_W-1:0] SEC_TRAIL  = 2'd3;

    typedef struct packed {
        logic [SEC_W-1:0]  section;
        logic [ELEM_W-1:0] element_number;
        logic [CHAR_W-1:0] char_out;
        logic              unit_last;
    } item_t;

    // Fixed length of data element k (1..12); unused codes end at once
    function automatic logic [POS_W-1:0] elem_len(input logic [ELEM_W-1:0] k);
        logic [POS_W-1:0] len;
        case (k)
            4'd1:    len = 5'd8;
            4'd2:    len = 5'd19;
            4'd3:    len = 5'd6;
            4'd4:    len = 5'd16;
            4'd5:    len = 5'd16;
            4'd6:    len = 5'd16;
            4'd7:    len = 5'd10;
            4'd8:    len = 5'd12;
            4'd9:    len = 5'd8;
            4'd10:   len = 5'd8;
            4'd11:   len = 5'd12;
            4'd12:   len = 5'd14;
            default: len = 5'd1;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/ifs_front.sv @@
// Front end: accepts characters, tracks the message layout and tags each character.
module ifs_front #(
    parameter int NUM_ELEMENTS = ifs_pkg::NUM_ELEMENTS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ifs_pkg::CHAR_W-1:0]  in_char,
    input  logic                        in_start,
    input  logic                        q_full,
    output logic                        q_push,
    output ifs_pkg::item_t              q_item
);

    typedef enum logic [1:0] {PH_TYPE, PH_BITMAP, PH_DATA, PH_TRAIL} phase_t;

    phase_t                           phase_reg, phase_next, cur_phase;
    logic [ifs_pkg::POS_W-1:0]        pos_reg, pos_next, cur_pos, pos_inc;
    logic [NUM_ELEMENTS-1:0]          pres_reg, pres_next, cur_pres;
    logic [ifs_pkg::ELEM_W-1:0]       elem_reg, elem_next, cur_elem;
    logic [ifs_pkg::ELEM_W-1:0]       search_after, found_k;
    logic                             accept;
    logic                             last;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // Classify the incoming character against the current layout state
    always_comb begin
        // a start mark restarts the layout before this character
        cur_phase = in_start ? PH_TYPE : phase_reg;
        cur_pos   = in_start ? '0 : pos_reg;
        cur_pres  = in_start ? '0 : pres_reg;
        cur_elem  = in_start ? '0 : elem_reg;
        pos_inc   = cur_pos + 5'd1;

        // record presence from the bitmap character
        for (int i = 0; i < NUM_ELEMENTS; i++) begin
            pres_next[i] = cur_pres[i] ||
                           (cur_phase == PH_BITMAP && cur_pos == ifs_pkg::POS_W'(i) &&
                            in_char == ifs_pkg::CHAR_ONE);
        end

        // priority encode the next present element above the current one
        search_after = (cur_phase == PH_DATA) ? cur_elem : '0;
        found_k      = '0;
        for (int i = NUM_ELEMENTS - 1; i >= 0; i--) begin
            if (pres_next[i] && ifs_pkg::ELEM_W'(i + 1) > search_after) begin
                found_k = ifs_pkg::ELEM_W'(i + 1);
            end
        end

        phase_next = cur_phase;
        pos_next   = cur_pos;
        elem_next  = cur_elem;
        last       = 1'b0;
        q_item.section        = ifs_pkg::SEC_TRAIL;
        q_item.element_number = '0;
        q_item.char_out       = in_char;

        unique case (cur_phase)
            PH_TYPE: begin
                q_item.section = ifs_pkg::SEC_TYPE;
                last = (pos_inc >= ifs_pkg::POS_W'(ifs_pkg::TYPE_LEN));
                if (last) begin
                    phase_next = PH_BITMAP;
                    pos_next   = '0;
                end else begin
                    pos_next = pos_inc;
                end
            end
            PH_BITMAP, PH_DATA: begin
                if (cur_phase == PH_BITMAP) begin
                    q_item.section = ifs_pkg::SEC_BITMAP;
                    last = (pos_inc >= ifs_pkg::POS_W'(NUM_ELEMENTS));
                end else begin
                    q_item.section        = ifs_pkg::SEC_DATA;
                    q_item.element_number = cur_elem;
                    last = (pos_inc >= ifs_pkg::elem_len(cur_elem));
                end
                if (last) begin
                    pos_next   = '0;
                    elem_next  = found_k;
                    phase_next = (found_k == '0) ? PH_TRAIL : PH_DATA;
                end else begin
                    pos_next = pos_inc;
                end
            end
            PH_TRAIL: begin
                q_item.section = ifs_pkg::SEC_TRAIL;
            end
            default: begin
                q_item.section = ifs_pkg::SEC_TRAIL;
            end
        endcase
        q_item.unit_last = last;
    end

    // Hold layout state; advance on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            pos_reg   <= '0;
            pres_reg  <= '0;
            elem_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            pres_reg  <= pres_next;
            elem_reg  <= elem_next;
        end
    end

endmodule

@@ hw/rtl/ifs_queue.sv @@
// Short queue of tagged characters between the front end and the output stage.
module ifs_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ifs_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output ifs_pkg::item_t head_item
);

    localparam int AW = $clog2(ifs_pkg::QUEUE_DEPTH);

    ifs_pkg::item_t  entry_reg [ifs_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg, count_next;

    assign full      = (count_reg == (AW + 1)'(ifs_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store pushed entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/ifs_back.sv @@
// Output stage: registers the queue head and drives the result stream.
module ifs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  ifs_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ifs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [ifs_pkg::SEC_W-1:0]     m_tuser,
    output logic                          m_tlast
);

    localparam int PAD_W = ifs_pkg::M_TDATA_W - ifs_pkg::CHAR_W - ifs_pkg::ELEM_W;

    logic           out_valid_reg;
    ifs_pkg::item_t out_item_reg;

    // Load when the output register is empty or being taken
    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold payload until the transfer completes
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_item_reg <= q_item;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_item_reg.char_out, out_item_reg.element_number};
    assign m_tuser  = out_item_reg.section;
    assign m_tlast  = out_item_reg.unit_last;

endmodule

@@ hw/rtl/iso8583_fixed_field_splitter_top.sv @@
// A result passes through a queue entry and then the output register before it reaches the result stream.
// Throughput: one character per cycle; the front end tags each character combinationally.
// The four-entry queue absorbs output stalls; input stalls only when the queue is full.
// Reset: synchronous active-low aresetn clears layout state, queue and output valid;
// the first character after reset starts a type indicator.
// Top level of the fixed field splitter: front end, queue and output stage.
module iso8583_fixed_field_splitter_top #(
    parameter int NUM_ELEMENTS = ifs_pkg::NUM_ELEMENTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ifs_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] char_in
    input  logic                          s_tuser,   // [0] msg_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [3:0] element_number, [11:4] char_out, [15:12] zero
    output logic [ifs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [ifs_pkg::SEC_W-1:0]     m_tuser,   // [1:0] section
    output logic                          m_tlast    // unit_last
);

    logic           q_push, q_pop, q_full, q_valid;
    ifs_pkg::item_t push_item, head_item;

    ifs_front #(
        .NUM_ELEMENTS(NUM_ELEMENTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_char   (s_tdata[ifs_pkg::CHAR_W-1:0]),
        .in_start  (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    ifs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head_item (head_item)
    );

    ifs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ hw/rtl/ifs_checker.sv @@
// Port-level checks on the fixed field splitter, bound to its top level.
module ifs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ifs_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ifs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ifs_pkg::SEC_W-1:0]     m_tuser,
    input logic                          m_tlast
);

    // Reset empties the queue and the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output valid or input stall after reset");

    // A stalled result holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Element number is non-zero exactly in data elements
    a_elem_section: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == ifs_pkg::SEC_DATA) ==
                      (m_tdata[ifs_pkg::ELEM_W-1:0] != '0)))
        else $error("element number does not match section");

    // Trailing characters never close a unit
    a_trail_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ifs_pkg::SEC_TRAIL |-> !m_tlast)
        else $error("trailing character marked last");

endmodule

bind iso8583_fixed_field_splitter_top ifs_checker u_ifs_checker (.*);

@@ sim/iso8583_fixed_field_splitter_top_tb.sv @@
// Self-checking testbench for the fixed field splitter: directed script, random messages.
module iso8583_fixed_field_splitter_top_tb;

    localparam int ITEMS       = 650;
    localparam int SETTLE_FROM = ITEMS - 100;
    localparam int STALL_LIMIT = 400;
    localparam int DRAIN_WAIT  = 8;
    localparam int REPORT_MAX  = 40;

    localparam logic [ifs_pkg::CHAR_W-1:0] CHAR_ZERO = 8'h30;

    typedef struct {
        logic [ifs_pkg::CHAR_W-1:0] ch;
        logic                       st;
        bit                         typed;
        ifs_pkg::item_t             want;
    } step_row_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ifs_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic                            s_tuser  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ifs_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [ifs_pkg::SEC_W-1:0]       m_tuser;
    logic                            m_tlast;

    // Length of data element k+1
    logic [ifs_pkg::POS_W-1:0] field_len [ifs_pkg::NUM_ELEMENTS] =
        '{5'd8, 5'd19, 5'd6, 5'd16, 5'd16, 5'd16, 5'd10, 5'd12, 5'd8, 5'd8, 5'd12, 5'd14};

    // Layout tracker state, reset values
    logic [ifs_pkg::SEC_W-1:0]        layout_phase   = ifs_pkg::SEC_TYPE;
    int                               layout_pos     = 0;
    logic [ifs_pkg::NUM_ELEMENTS-1:0] present_marks  = '0;
    logic [ifs_pkg::ELEM_W-1:0]       open_elem      = '0;

    ifs_pkg::item_t  expected_tags [$];
    step_row_t       script [$];
    ifs_pkg::item_t  seen_tag;
    ifs_pkg::item_t  due_tag;
    int         mismatches   = 0;
    int         sent         = 0;
    int         quiet_cycles = 0;
    int         hold_left    = 0;
    int         rx_cycle     = 0;
    bit         settle       = 1'b0;
    bit         feed_gaps    = 1'b0;
    bit         drain_gaps   = 1'b1;

    iso8583_fixed_field_splitter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance to the lowest present element above 'after', else to trailing
    function automatic void open_next(input int after);
        int k;
        layout_pos   = 0;
        layout_phase = ifs_pkg::SEC_TRAIL;
        open_elem    = '0;
        for (k = ifs_pkg::NUM_ELEMENTS; k > after; k--) begin
            if (present_marks[k-1]) begin
                layout_phase = ifs_pkg::SEC_DATA;
                open_elem    = ifs_pkg::ELEM_W'(k);
            end
        end
    endfunction

    // Tag one character and advance the layout tracker
    function automatic ifs_pkg::item_t tag_char(input logic [ifs_pkg::CHAR_W-1:0] c,
                                                input logic st);
        ifs_pkg::item_t t;
        t          = '0;
        t.char_out = c;
        if (st) begin
            layout_phase  = ifs_pkg::SEC_TYPE;
            layout_pos    = 0;
            present_marks = '0;
            open_elem     = '0;
        end
        case (layout_phase)
            ifs_pkg::SEC_TYPE: begin
                t.section   = ifs_pkg::SEC_TYPE;
                t.unit_last = (layout_pos + 1 >= ifs_pkg::TYPE_LEN);
                if (t.unit_last) begin
                    layout_phase = ifs_pkg::SEC_BITMAP;
                    layout_pos   = 0;
                end else begin
                    layout_pos++;
                end
            end
            ifs_pkg::SEC_BITMAP: begin
                t.section = ifs_pkg::SEC_BITMAP;
                if (c == ifs_pkg::CHAR_ONE)
                    present_marks[layout_pos] = 1'b1;
                t.unit_last = (layout_pos + 1 >= ifs_pkg::NUM_ELEMENTS);
                if (t.unit_last)
                    open_next(0);
                else
                    layout_pos++;
            end
            ifs_pkg::SEC_DATA: begin
                t.section        = ifs_pkg::SEC_DATA;
                t.element_number = open_elem;
                t.unit_last      = (layout_pos + 1 >= field_len[open_elem-1]);
                if (t.unit_last)
                    open_next(open_elem);
                else
                    layout_pos++;
            end
            default: begin
                t.section = ifs_pkg::SEC_TRAIL;
            end
        endcase
        return t;
    endfunction

    task automatic report_mismatch(input string what, input ifs_pkg::item_t got,
                                   input ifs_pkg::item_t want);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display({"MISMATCH %s: got sec %0d elem %0d char %02h last %0b, ",
                      "want sec %0d elem %0d char %02h last %0b"},
                     what, got.section, got.element_number, got.char_out, got.unit_last,
                     want.section, want.element_number, want.char_out, want.unit_last);
    endtask

    task automatic add_row(input logic [ifs_pkg::CHAR_W-1:0] ch, input logic st,
                           input bit typed, input logic [ifs_pkg::SEC_W-1:0] sec,
                           input int elem, input logic last);
        step_row_t r;
        r.ch                  = ch;
        r.st                  = st;
        r.typed               = typed;
        r.want.section        = sec;
        r.want.element_number = ifs_pkg::ELEM_W'(elem);
        r.want.char_out       = ch;
        r.want.unit_last      = last;
        script.push_back(r);
    endtask

    // Offer one character, hold it until the transfer, then log its expected tag
    task automatic push_char(input logic [ifs_pkg::CHAR_W-1:0] c, input logic st,
                             input bit typed, input ifs_pkg::item_t want);
        ifs_pkg::item_t t;
        if (!settle && feed_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        t = tag_char(c, st);
        expected_tags.push_back(typed ? want : t);
        sent++;
        if (sent >= SETTLE_FROM)
            settle = 1'b1;
        @(negedge aclk);
    endtask

    // One message: type indicator, bitmap, its elements and up to five trailing characters, sometimes cut short
    task automatic send_message();
        int                               odds;
        int                               body;
        int                               k;
        logic [ifs_pkg::NUM_ELEMENTS-1:0] marks;
        logic [ifs_pkg::CHAR_W-1:0]       c;
        odds  = $urandom_range(0, 4);
        marks = '0;
        for (k = 0; k < ifs_pkg::TYPE_LEN; k++)
            push_char(ifs_pkg::CHAR_W'($urandom_range(0, 255)),
                      (k == 0) && ($urandom_range(0, 9) != 0), 1'b0, '0);
        for (k = 0; k < ifs_pkg::NUM_ELEMENTS; k++) begin
            if ($urandom_range(1, 4) <= odds)
                c = ifs_pkg::CHAR_ONE;
            else if ($urandom_range(0, 1) != 0)
                c = CHAR_ZERO;
            else
                c = ifs_pkg::CHAR_W'($urandom_range(0, 255));
            if (c == ifs_pkg::CHAR_ONE)
                marks[k] = 1'b1;
            push_char(c, 1'b0, 1'b0, '0);
        end
        body = $urandom_range(0, 5);
        for (k = 0; k < ifs_pkg::NUM_ELEMENTS; k++)
            if (marks[k])
                body += field_len[k];
        if ($urandom_range(0, 7) == 0)
            body = $urandom_range(0, body);
        for (k = 0; k < body; k++)
            push_char(ifs_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    endtask

    // Result side: stall in bursts, switching between busy and quiet stretches
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 97 == 0)
            drain_gaps <= ($urandom_range(0, 2) != 0);
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!settle && drain_gaps && $urandom_range(0, 5) == 0) begin
            hold_left <= $urandom_range(0, 16);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check each result transfer against the oldest expected tag
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_tag.section        = m_tuser;
            seen_tag.element_number = m_tdata[3:0];
            seen_tag.char_out       = m_tdata[11:4];
            seen_tag.unit_last      = m_tlast;
            if (expected_tags.size() == 0) begin
                report_mismatch("unexpected result", seen_tag, '0);
            end else begin
                due_tag = expected_tags.pop_front();
                if (seen_tag !== due_tag)
                    report_mismatch("wrong tag", seen_tag, due_tag);
            end
        end
    end

    // Give up when no transfer happens on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("iso8583_fixed_field_splitter_top verification failed");
            $finish;
        end
    end

    initial begin
        static logic [ifs_pkg::CHAR_W-1:0] near_miss [ifs_pkg::NUM_ELEMENTS] =
            '{8'h30, 8'h00, 8'hFF, 8'h32, 8'h30, 8'h11, 8'hB1, 8'h30, 8'h30, 8'h71, 8'h30, 8'h21};
        int i;

        // Type indicator straight after reset, no start mark
        add_row(8'h00, 1'b0, 1'b1, ifs_pkg::SEC_TYPE, 0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b1, ifs_pkg::SEC_TYPE, 0, 1'b0);
        add_row(8'h30, 1'b0, 1'b1, ifs_pkg::SEC_TYPE, 0, 1'b0);
        add_row(8'h32, 1'b0, 1'b1, ifs_pkg::SEC_TYPE, 0, 1'b1);
        // Bitmap with no '1' anywhere: empty, near misses included
        for (i = 0; i < ifs_pkg::NUM_ELEMENTS; i++)
            add_row(near_miss[i], 1'b0, 1'b1, ifs_pkg::SEC_BITMAP, 0,
                    i == ifs_pkg::NUM_ELEMENTS - 1);
        // Empty bitmap leaves only trailing characters
        add_row(ifs_pkg::CHAR_ONE, 1'b0, 1'b1, ifs_pkg::SEC_TRAIL, 0, 1'b0);
        add_row(8'hA5, 1'b0, 1'b1, ifs_pkg::SEC_TRAIL, 0, 1'b0);
        // Start mark out of trailing, then again inside the type indicator
        add_row(8'h30, 1'b1, 1'b1, ifs_pkg::SEC_TYPE, 0, 1'b0);
        add_row(8'h38, 1'b0, 1'b1, ifs_pkg::SEC_TYPE, 0, 1'b0);
        add_row(8'h30, 1'b1, 1'b1, ifs_pkg::SEC_TYPE, 0, 1'b0);
        add_row(8'h32, 1'b0, 1'b0, ifs_pkg::SEC_TYPE, 0, 1'b0);
        add_row(8'h31, 1'b0, 1'b0, ifs_pkg::SEC_TYPE, 0, 1'b0);
        add_row(8'h30, 1'b0, 1'b0, ifs_pkg::SEC_TYPE, 0, 1'b0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            feed_gaps = ($urandom_range(0, 1) != 0);
            push_char(script[i].ch, script[i].st, script[i].typed, script[i].want);
        end

        // Mostly whole messages, with bursts of noise between them
        while (sent < ITEMS) begin
            feed_gaps = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 6))
                    push_char(ifs_pkg::CHAR_W'($urandom_range(0, 255)),
                              $urandom_range(0, 3) == 0, 1'b0, '0);
            end else begin
                send_message();
            end
        end
        s_tvalid <= 1'b0;

        while (expected_tags.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("iso8583_fixed_field_splitter_top verification clean");
        else
            $display("iso8583_fixed_field_splitter_top verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ifs_pkg.sv
hw/rtl/ifs_front.sv
hw/rtl/ifs_queue.sv
hw/rtl/ifs_back.sv
hw/rtl/iso8583_fixed_field_splitter_top.sv
hw/rtl/ifs_checker.sv
sim/iso8583_fixed_field_splitter_top_tb.sv
